>>> rtl/core/url_percent_codec_defines.svh
// Assertion macros shared by the URL percent codec RTL.
// Depends on nothing; expects i_clk and i_rst_n in the module that uses them.
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define UPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define UPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/upc_pkg.sv
// Package for the URL percent codec: word types, character constants and
// the character classification helpers. Depends on nothing.
`default_nettype none

package upc_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Most result words one source byte can produce.
    localparam int unsigned JOB_BYTES = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } t_out_word;

    // Work for the back end: up to three bytes, how many, and whether the
    // last of them closes the string.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [1:0]                cnt;
        logic                      done;
    } t_job;

    function automatic logic upc_is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Value of a hex digit character; only meaningful when upc_is_hex holds.
    function automatic logic [3:0] upc_hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    // Uppercase hex digit character for a nibble.
    function automatic logic [7:0] upc_hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

    // Characters that pass through the encoder unchanged.
    function automatic logic upc_passes(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h2E ||
               c == 8'h5F || c == 8'h7E;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/upc_front.sv
// Front end of the URL percent codec: holds the mode register and the escape
// state, and turns each accepted source word into a job. Depends on upc_pkg.
`default_nettype none

module upc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_push,
    input  wire upc_pkg::t_in_word i_in_word,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output upc_pkg::t_job          o_job
);
    import upc_pkg::*;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PCT,
        ESC_HEX
    } t_esc;

    t_esc       r_esc, n_esc;
    logic [7:0] r_held, n_held;
    logic       r_decode;
    t_job       n_job;
    logic [1:0] k;
    logic       do_fresh;
    logic       accept;
    logic [7:0] b;
    logic       last;
    logic       b_hex;

    assign b      = i_in_word.in_byte;
    assign last   = i_in_word.end_of_string;
    assign b_hex  = upc_is_hex(b);
    assign accept = i_push && !i_q_full;

    always_comb begin
        n_esc    = r_esc;
        n_held   = r_held;
        n_job    = '0;
        k        = 2'd0;
        do_fresh = 1'b0;
        if (!r_decode) begin
            n_esc = ESC_IDLE;
            if (upc_passes(b)) begin
                n_job.bytes[k] = b;
                k = k + 2'd1;
            end else if (b == CH_SPACE) begin
                n_job.bytes[k] = CH_PLUS;
                k = k + 2'd1;
            end else begin
                n_job.bytes[k] = CH_PERCENT;
                k = k + 2'd1;
                n_job.bytes[k] = upc_hex_digit(b[7:4]);
                k = k + 2'd1;
                n_job.bytes[k] = upc_hex_digit(b[3:0]);
                k = k + 2'd1;
            end
        end else begin
            n_esc = ESC_IDLE;
            unique case (r_esc)
                ESC_PCT: begin
                    if (b_hex) begin
                        if (last) begin
                            n_job.bytes[k] = CH_PERCENT;
                            k = k + 2'd1;
                            n_job.bytes[k] = b;
                            k = k + 2'd1;
                        end else begin
                            n_held = b;
                            n_esc  = ESC_HEX;
                        end
                    end else begin
                        n_job.bytes[k] = CH_PERCENT;
                        k = k + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                ESC_HEX: begin
                    if (b_hex) begin
                        n_job.bytes[k] = {upc_hex_val(r_held), upc_hex_val(b)};
                        k = k + 2'd1;
                    end else begin
                        n_job.bytes[k] = CH_PERCENT;
                        k = k + 2'd1;
                        n_job.bytes[k] = r_held;
                        k = k + 2'd1;
                        do_fresh = 1'b1;
                    end
                    n_held = '0;
                end
                ESC_IDLE: do_fresh = 1'b1;
                default:  do_fresh = 1'b1;
            endcase
            // The byte is handled as if no escape were pending.
            if (do_fresh) begin
                if (b == CH_PERCENT) begin
                    if (last) begin
                        n_job.bytes[k] = CH_PERCENT;
                        k = k + 2'd1;
                    end else begin
                        n_esc = ESC_PCT;
                    end
                end else if (b == CH_PLUS) begin
                    n_job.bytes[k] = CH_SPACE;
                    k = k + 2'd1;
                end else begin
                    n_job.bytes[k] = b;
                    k = k + 2'd1;
                end
            end
            if (last) begin
                n_esc  = ESC_IDLE;
                n_held = '0;
            end
        end
        n_job.cnt  = k;
        n_job.done = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode <= 1'b0;
            r_esc    <= ESC_IDLE;
            r_held   <= '0;
        end else if (i_cfg_we) begin
            r_decode <= i_cfg_wdata;
            r_esc    <= ESC_IDLE;
            r_held   <= '0;
        end else if (accept) begin
            r_esc  <= n_esc;
            r_held <= n_held;
        end
    end

    assign o_q_push = accept && (n_job.cnt != 2'd0);
    assign o_job    = n_job;

endmodule

`default_nettype wire

>>> rtl/core/upc_queue.sv
// Two-entry job queue between the front and back ends of the URL percent
// codec. Depends on upc_pkg.
`default_nettype none

module upc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire upc_pkg::t_job i_job,
    input  wire logic          i_pop,
    output upc_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);
    import upc_pkg::*;

    t_job       r_head;
    t_job       r_tail;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({i_push, i_pop})
                2'b11: begin
                    if (r_cnt == 2'd1) begin
                        r_head <= i_job;
                    end else begin
                        r_head <= r_tail;
                        r_tail <= i_job;
                    end
                end
                2'b10: begin
                    if (r_cnt == 2'd0) begin
                        r_head <= i_job;
                    end else begin
                        r_tail <= i_job;
                    end
                    r_cnt <= r_cnt + 2'd1;
                end
                2'b01: begin
                    r_head <= r_tail;
                    r_cnt  <= r_cnt - 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_job   = r_head;
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

`default_nettype wire

>>> rtl/core/upc_back.sv
// Back end of the URL percent codec: unpacks one job at a time into result
// words through a single output register. Depends on upc_pkg and the macros.
`default_nettype none
`include "url_percent_codec_defines.svh"

module upc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire upc_pkg::t_job i_job,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output upc_pkg::t_out_word o_out_word
);
    import upc_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_word  r_out;
    logic       out_free;
    logic       emit;
    logic       fin;
    logic       take;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_busy && out_free;
    assign fin      = emit && (r_idx == r_job.cnt - 2'd1);
    assign take     = !i_q_empty && (!r_busy || fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out.out_byte    <= r_job.bytes[r_idx];
                r_out.run_last    <= fin;
                r_out.string_done <= fin && r_job.done;
                r_out_valid       <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_job  <= i_job;
                r_idx  <= 2'd0;
                r_busy <= 1'b1;
            end else begin
                if (emit) begin
                    r_idx <= r_idx + 2'd1;
                end
                if (fin) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_q_pop    = take;
    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

    `UPC_ASSERT_NOW(a_job_not_empty, r_busy, r_job.cnt != 2'd0, "busy with an empty job")
    `UPC_ASSERT_NOW(a_idx_in_job, r_busy, r_idx < r_job.cnt, "byte index beyond job")
    `UPC_ASSERT_NEXT(a_job_continues, emit && !fin, r_busy, "job dropped before last byte")
    `UPC_ASSERT_NOW(a_done_on_last, r_out_valid && r_out.string_done, r_out.run_last, "string end flagged on a word that is not the last of its byte")

endmodule

`default_nettype wire

>>> rtl/core/url_percent_codec.sv
// URL form codec (percent-encoding) on a byte stream, top level.
// Depends on upc_pkg, upc_front, upc_queue, upc_back and the macros header.
//
// The block converts one source byte per accepted input word. With the mode
// register at 0 it encodes: letters, digits and - . _ ~ pass unchanged, a
// space becomes '+', and every other byte becomes '%' and two uppercase hex
// digits. With the mode register at 1 it decodes: '%' with two hex digits of
// either case becomes one byte, '+' becomes a space, and an escape that is cut
// short or broken is emitted literally before the byte that broke it is
// handled afresh; a pending escape is flushed literally at end of string.
// Each source byte gives zero to three result words; run_last marks the final
// word of a byte and string_done the final word of the string. Writing the
// mode register drops any escape in progress, so write it only while idle.
// Rate: an input word is accepted in any cycle the two-entry job queue has
// room, and the output register emits one result word per cycle while the
// consumer pops it, so that single output register sets the sustained rate.
// The first word of a byte goes through the job queue and the back end's job
// register before it reaches the output register.
`default_nettype none

module url_percent_codec (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire upc_pkg::t_in_word  i_in_word,
    output logic                    empty,
    input  wire logic               pop,
    output upc_pkg::t_out_word      o_out_word
);
    import upc_pkg::*;

    // Job path from the classifier through the queue to the unpacker.
    t_job q_in_job;
    t_job q_out_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // The front end classifies each word and builds its job in the same cycle.
    upc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_job       (q_in_job)
    );

    // The queue lets the front keep accepting while the back end is stalled.
    upc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end unpacks each head job, one result word per cycle unless the output stalls.
    upc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_out_job),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

    // Input is refused only while the job queue is full.
    assign full = q_full;

endmodule

`default_nettype wire
